@@ hdl/phtlp_pkg.sv @@
package phtlp_pkg;

  localparam int TableSize = 1024;
  localparam int IdxW = $clog2(TableSize);
  localparam int CntW = IdxW + 1;
  localparam int KeyW = 64;
  localparam int LenW = 4;
  localparam int ValW = 32;
  localparam int EntW = 1 + LenW + KeyW + ValW;

  typedef logic [2:0] status_t;
  localparam status_t ST_FOUND     = 3'd0;
  localparam status_t ST_NOT_FOUND = 3'd1;
  localparam status_t ST_INSERTED  = 3'd2;
  localparam status_t ST_UPDATED   = 3'd3;
  localparam status_t ST_INVALID   = 3'd4;
  localparam status_t ST_FULL      = 3'd5;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_HASH, S_READ, S_CHECK, S_DONE
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic hash_step;
    logic set_home;
    logic rd;
    logic probe_next;
    logic wr;
    logic set_result;
    status_t result_code;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic plate_ok;
    logic hash_last;
    logic hit;
    logic empty;
    logic probed_all;
    logic req_ins;
  } sts_t;

  function automatic logic is_letter(logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic plate_valid(logic [KeyW-1:0] key, logic [LenW-1:0] len);
    logic [LenW-1:0] sp;
    logic found_sp, ok, num;
    logic [LenW-1:0] ndig;
    logic [7:0] c;
    sp = len;
    found_sp = 1'b0;
    ok = 1'b1;
    for (int i = 0; i < 8; i++) begin
      c = key[8*i +: 8];
      if (!found_sp && (LenW'(i) < len) && c == 8'h20) begin
        sp = LenW'(i);
        found_sp = 1'b1;
      end
    end
    num = is_digit(key[7:0]);
    for (int i = 0; i < 8; i++) begin
      c = key[8*i +: 8];
      if (LenW'(i) < len) begin
        if (found_sp) begin
          if (LenW'(i) < sp && !is_letter(c)) ok = 1'b0;
          if (LenW'(i) > sp && !is_digit(c)) ok = 1'b0;
        end else begin
          if (num && !is_digit(c)) ok = 1'b0;
          if (!num && !is_letter(c)) ok = 1'b0;
        end
      end
    end
    ndig = len - sp - LenW'(1);
    if (len == '0 || len > LenW'(8)) return 1'b0;
    if (!ok) return 1'b0;
    if (found_sp) begin
      return (sp >= LenW'(1) && sp <= LenW'(5) && ndig >= LenW'(1) && ndig <= LenW'(2))
          || (sp == LenW'(6) && ndig == LenW'(1));
    end
    if (num) return len <= LenW'(3);
    return len <= LenW'(7);
  endfunction

endpackage

@@ hdl/phtlp_ctrl.sv @@
module phtlp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             out_valid,
  input  logic             out_ready,
  input  phtlp_pkg::sts_t  sts,
  output phtlp_pkg::cmd_t  cmd
);
  import phtlp_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

  // output register frees once its beat is taken
  logic out_free;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE:  if (in_valid) state_nxt = S_HASH;
      S_HASH: begin
        if (!sts.plate_ok) state_nxt = S_DONE;
        else if (sts.hash_last) state_nxt = S_READ;
      end
      S_READ:  state_nxt = S_CHECK;
      S_CHECK: begin
        if (sts.empty || sts.hit || sts.probed_all) state_nxt = S_DONE;
        else state_nxt = S_READ;
      end
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.result_code = ST_FULL;
    in_ready = 1'b0;
    case (state_r)
      S_CLEAR: cmd.clr_step = 1'b1;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_HASH: begin
        if (!sts.plate_ok) begin
          cmd.set_result = 1'b1;
          cmd.result_code = ST_INVALID;
        end else begin
          cmd.hash_step = 1'b1;
          cmd.set_home = sts.hash_last;
        end
      end
      S_READ: cmd.rd = 1'b1;
      S_CHECK: begin
        if (sts.empty) begin
          cmd.set_result = 1'b1;
          cmd.result_code = sts.req_ins ? ST_INSERTED : ST_NOT_FOUND;
          cmd.wr = sts.req_ins;
        end else if (sts.hit) begin
          cmd.set_result = 1'b1;
          cmd.result_code = sts.req_ins ? ST_UPDATED : ST_FOUND;
          cmd.wr = sts.req_ins;
        end else if (sts.probed_all) begin
          cmd.set_result = 1'b1;
          cmd.result_code = ST_FULL;
        end else begin
          cmd.probe_next = 1'b1;
        end
      end
      S_DONE: cmd.out_load = out_free;
      default: ;
    endcase
  end

  a_wr_only_check: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> state_r == S_CHECK && sts.req_ins) else $error("write outside check");
  a_clear_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !in_ready) else $error("accept during clear");
  a_load_then_hash: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_HASH) else $error("load did not start hash");

endmodule

@@ hdl/phtlp_dp.sv @@
module phtlp_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  phtlp_pkg::cmd_t               cmd,
  output phtlp_pkg::sts_t               sts,
  input  logic                          in_req_type,
  input  logic [phtlp_pkg::KeyW-1:0]    in_key_chars,
  input  logic [phtlp_pkg::LenW-1:0]    in_key_length,
  input  logic signed [phtlp_pkg::ValW-1:0] in_new_value,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [2:0]                    out_status,
  output logic signed [phtlp_pkg::ValW-1:0] out_found_value,
  output logic [phtlp_pkg::IdxW-1:0]    out_slot_index
);
  import phtlp_pkg::*;

  // slot store: used flag in the same word, cleared by a sweep after reset
  logic [EntW-1:0] mem [TableSize];
  logic [EntW-1:0] rd_data_r;

  logic            req_r;
  logic [KeyW-1:0] key_r;
  logic [LenW-1:0] len_r;
  logic [ValW-1:0] val_r;
  logic            ok_r;
  logic [31:0]     hash_r;
  logic [LenW-1:0] hcnt_r;
  logic [IdxW-1:0] idx_r;
  logic [CntW-1:0] probes_r;
  logic [IdxW-1:0] clr_r;
  status_t         res_st_r;
  logic [ValW-1:0] res_val_r;
  logic [IdxW-1:0] res_idx_r;
  logic            out_valid_r;

  logic [KeyW-1:0] key_mask;
  always_comb begin
    for (int i = 0; i < 8; i++)
      key_mask[8*i +: 8] = (LenW'(i) < in_key_length) ? in_key_chars[8*i +: 8] : 8'h00;
  end

  logic [31:0] hash_nxt, mag;
  logic [7:0]  ch;
  assign ch = key_r[8*hcnt_r[2:0] +: 8];
  assign hash_nxt = {24'h0, ch} + (hash_r << 3) + (hash_r << 5) - hash_r;
  assign mag = hash_nxt[31] ? (32'h0 - hash_nxt) : hash_nxt;

  logic            e_used;
  logic [LenW-1:0] e_len;
  logic [KeyW-1:0] e_key;
  logic [ValW-1:0] e_val;
  assign {e_used, e_len, e_key, e_val} = rd_data_r;

  always_ff @(posedge clk) begin
    if (cmd.clr_step) mem[clr_r] <= '0;
    else if (cmd.wr) mem[idx_r] <= {1'b1, len_r, key_r, val_r};
    if (cmd.rd) rd_data_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (cmd.clr_step) clr_r <= clr_r + IdxW'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= in_req_type;
      key_r  <= key_mask;
      len_r  <= in_key_length;
      val_r  <= in_new_value;
      ok_r   <= plate_valid(key_mask, in_key_length);
      hash_r <= '0;
      hcnt_r <= '0;
    end
    if (cmd.hash_step) begin
      hash_r <= hash_nxt;
      hcnt_r <= hcnt_r + LenW'(1);
    end
    if (cmd.set_home) begin
      idx_r    <= mag[IdxW-1:0];
      probes_r <= '0;
    end
    if (cmd.probe_next) begin
      idx_r    <= idx_r + IdxW'(1);
      probes_r <= probes_r + CntW'(1);
    end
    if (cmd.set_result) begin
      res_st_r  <= cmd.result_code;
      res_val_r <= (cmd.result_code == ST_FOUND) ? e_val : '1;
      res_idx_r <= (cmd.result_code == ST_FOUND || cmd.result_code == ST_INSERTED ||
                    cmd.result_code == ST_UPDATED) ? idx_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  logic [2:0]      ost_r;
  logic [ValW-1:0] oval_r;
  logic [IdxW-1:0] oidx_r;
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      ost_r  <= res_st_r;
      oval_r <= res_val_r;
      oidx_r <= res_idx_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = ost_r;
  assign out_found_value = oval_r;
  assign out_slot_index = oidx_r;

  assign sts.clr_last   = clr_r == IdxW'(TableSize - 1);
  assign sts.plate_ok   = ok_r;
  assign sts.hash_last  = (hcnt_r + LenW'(1)) == len_r;
  assign sts.empty      = !e_used;
  assign sts.hit        = e_used && e_key == key_r && e_len == len_r;
  assign sts.probed_all = probes_r == CntW'(TableSize - 1);
  assign sts.req_ins    = req_r;

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status)) else $error("result beat changed");
  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.probe_next |-> probes_r < CntW'(TableSize - 1)) else $error("probe overrun");
  a_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr && cmd.clr_step)) else $error("write during clear");

endmodule

@@ hdl/plate_hash_table_linear_probe_top.sv @@
// channel | handshake            | payload
// in      | in_valid / in_ready  | req_type, key_chars, key_length, new_value
// out     | out_valid / out_ready| status, found_value, slot_index
// An item is accepted, then hashed one character per cycle through the hash accumulator;
// each probed slot is then read from the slot RAM and checked, and at the end the result
// is loaded into the output register. Invalid plates skip probing.
// After reset a sweep clears all 1024 slots of the slot RAM; no beat is taken meanwhile.
// A stalled result holds the block in its final state until the beat is taken.
module plate_hash_table_linear_probe_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_req_type,
  input  logic [phtlp_pkg::KeyW-1:0]          in_key_chars,
  input  logic [phtlp_pkg::LenW-1:0]          in_key_length,
  input  logic signed [phtlp_pkg::ValW-1:0]   in_new_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [2:0]                          out_status,
  output logic signed [phtlp_pkg::ValW-1:0]   out_found_value,
  output logic [phtlp_pkg::IdxW-1:0]          out_slot_index
);
  import phtlp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  phtlp_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  phtlp_dp u_dp (
    .clk, .rst_n, .cmd, .sts, .in_req_type, .in_key_chars, .in_key_length,
    .in_new_value, .out_ready, .out_valid, .out_status, .out_found_value,
    .out_slot_index
  );

endmodule
